/* rtl/rotation_matrix_to_quaternion_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion block
// Each macro expands to a clocked assertion in simulation and to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge outside reset
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RMQ_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define RMQ_ASSERT(lbl, prop, msg)
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned FracBitsDef = 14;
  localparam int unsigned DataW       = 16;
  localparam int unsigned NumW        = 17;

  // Branch codes
  localparam logic [1:0] BrTrace = 2'd0;
  localparam logic [1:0] BrM00   = 2'd1;
  localparam logic [1:0] BrM11   = 2'd2;
  localparam logic [1:0] BrM22   = 2'd3;

  typedef struct packed {
    logic signed [DataW-1:0] m00;
    logic signed [DataW-1:0] m01;
    logic signed [DataW-1:0] m02;
    logic signed [DataW-1:0] m10;
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m20;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
  } rmq_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] qw;
    logic signed [DataW-1:0] qx;
    logic signed [DataW-1:0] qy;
    logic signed [DataW-1:0] qz;
    logic [1:0]              branch;
    logic                    invalid;
  } rmq_rsp_t;

  // Side data carried along the root cells
  typedef struct packed {
    logic [1:0]             branch;
    logic                   invalid;
    logic signed [NumW-1:0] n0;
    logic signed [NumW-1:0] n1;
    logic signed [NumW-1:0] n2;
  } rmq_side_t;

  // Side data carried along the divider cells
  typedef struct packed {
    logic [1:0] branch;
    logic       invalid;
    logic [2:0] neg;
    logic [2:0] ovf;
  } rmq_dside_t;

endpackage

/* rtl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, radicand and numerators for one request.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned RADW      = 19,
  parameter int unsigned VW        = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  rmq_pkg::rmq_req_t req_i,
  output logic              vld_o,
  output rmq_pkg::rmq_side_t side_o,
  output logic [VW-1:0]     v_o
);
  import rmq_pkg::*;

  localparam logic signed [RADW-1:0] One =
    {{(RADW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [RADW-1:0] e00, e11, e22, tr, rad;
  logic [1:0]             br;
  logic signed [NumW-1:0] n0, n1, n2;
  logic                   bad;
  logic                   vld_q;
  rmq_side_t              side_q;
  logic [VW-1:0]          v_q;

  // Pick the branch and its radicand
  always_comb begin
    e00 = RADW'(req_i.m00);
    e11 = RADW'(req_i.m11);
    e22 = RADW'(req_i.m22);
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      br  = BrTrace;
      rad = One + tr;
      n0  = NumW'(req_i.m21) - NumW'(req_i.m12);
      n1  = NumW'(req_i.m02) - NumW'(req_i.m20);
      n2  = NumW'(req_i.m10) - NumW'(req_i.m01);
    end else if (e00 > e11 && e00 > e22) begin
      br  = BrM00;
      rad = One + e00 - e11 - e22;
      n0  = NumW'(req_i.m21) - NumW'(req_i.m12);
      n1  = NumW'(req_i.m01) + NumW'(req_i.m10);
      n2  = NumW'(req_i.m02) + NumW'(req_i.m20);
    end else if (e11 > e22) begin
      br  = BrM11;
      rad = One + e11 - e00 - e22;
      n0  = NumW'(req_i.m02) - NumW'(req_i.m20);
      n1  = NumW'(req_i.m01) + NumW'(req_i.m10);
      n2  = NumW'(req_i.m12) + NumW'(req_i.m21);
    end else begin
      br  = BrM22;
      rad = One + e22 - e00 - e11;
      n0  = NumW'(req_i.m10) - NumW'(req_i.m01);
      n1  = NumW'(req_i.m02) + NumW'(req_i.m20);
      n2  = NumW'(req_i.m12) + NumW'(req_i.m21);
    end
    bad = (rad <= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Hold the radicand scaled by one, zero when it is not positive
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= '{branch: br, invalid: bad, n0: n0, n1: n1, n2: n2};
      v_q    <= bad ? '0 : {rad[RADW-2:0], {FRAC_BITS{1'b0}}};
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign v_o    = v_q;
endmodule

/* rtl/rmq_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One result bit of the integer square root: trial subtract and shift on.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
  parameter int unsigned SW  = 33,
  parameter int unsigned RTW = 16,
  parameter int unsigned BIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  rmq_pkg::rmq_side_t side_i,
  input  logic [SW-1:0]      rem_i,
  input  logic [RTW-1:0]     q_i,
  output logic               vld_o,
  output rmq_pkg::rmq_side_t side_o,
  output logic [SW-1:0]      rem_o,
  output logic [RTW-1:0]     q_o
);
  import rmq_pkg::*;

  logic [SW-1:0]  sub;
  logic           take;
  logic [SW-1:0]  rem_d, rem_q;
  logic [RTW-1:0] q_d, q_q;
  logic           vld_q;
  rmq_side_t      side_q;

  // Test whether this bit can be set in the root
  always_comb begin
    sub   = (SW'(q_i) << (BIT + 1)) + (SW'(1) << (2 * BIT));
    take  = (rem_i >= sub);
    rem_d = take ? rem_i - sub : rem_i;
    q_d   = take ? (q_i | (RTW'(1) << BIT)) : q_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      q_q    <= q_d;
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
endmodule

/* rtl/rmq_div_cell.sv */
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit for three restoring dividers that share a divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
  parameter int unsigned CW  = 64,
  parameter int unsigned QW  = 16,
  parameter int unsigned DW  = 17,
  parameter int unsigned OW  = 15,
  parameter int unsigned BIT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  rmq_pkg::rmq_dside_t side_i,
  input  logic [DW-1:0]       d_i,
  input  logic [OW-1:0]       own_i,
  input  logic [CW-1:0]       rem_i [3],
  input  logic [QW-1:0]       q_i [3],
  output logic                vld_o,
  output rmq_pkg::rmq_dside_t side_o,
  output logic [DW-1:0]       d_o,
  output logic [OW-1:0]       own_o,
  output logic [CW-1:0]       rem_o [3],
  output logic [QW-1:0]       q_o [3]
);
  import rmq_pkg::*;

  logic [CW-1:0] dsh;
  logic [CW-1:0] rem_d [3];
  logic [QW-1:0] q_d [3];
  logic [CW-1:0] rem_q [3];
  logic [QW-1:0] q_q [3];
  logic          vld_q;
  rmq_dside_t    side_q;
  logic [DW-1:0] d_q;
  logic [OW-1:0] own_q;

  // Subtract the shifted divisor where it fits
  always_comb begin
    dsh = CW'(d_i) << BIT;
    for (int k = 0; k < 3; k++) begin
      if (rem_i[k] >= dsh) begin
        rem_d[k] = rem_i[k] - dsh;
        q_d[k]   = q_i[k] | (QW'(1) << BIT);
      end else begin
        rem_d[k] = rem_i[k];
        q_d[k]   = q_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      d_q    <= d_i;
      own_q  <= own_i;
      rem_q  <= rem_d;
      q_q    <= q_d;
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign d_o    = d_q;
  assign own_o  = own_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix to a unit quaternion, four-branch method.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid_i / in_ready_o / in_req_i) takes the nine
//   matrix elements; the response channel (out_valid_o / out_ready_i /
//   out_rsp_o) returns qw..qz, the branch taken and the invalid flag.
//   Every request gives exactly one response, in order.
//   Throughput: one request per cycle unless a waiting response stalls the chain.
//   Pipeline: front register, one root cell per bit of the root width RTW,
//   divider setup register, one divider cell per quotient bit (QW = FRAC_BITS + 2)
//   and response register; with FRAC_BITS = 14, RTW = 16 and QW = 16.
//   The whole chain advances together: when the response register holds an
//   unread response, in_ready_o drops and every cell holds its data.
//   Reset clears all valid bits; the chain is empty afterwards and a
//   request is taken in the first cycle.
//   A non-positive radicand gives zero components with invalid set.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmq_pkg::rmq_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rmq_pkg::rmq_rsp_t out_rsp_o
);
  import rmq_pkg::*;

  localparam int unsigned RADW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int unsigned VW   = RADW - 1 + FRAC_BITS;
  localparam int unsigned RTW  = (VW + 1) / 2;
  localparam int unsigned SW   = 2 * RTW + 1;
  localparam int unsigned QW   = FRAC_BITS + 2;
  localparam int unsigned DW   = RTW + 1;
  localparam int unsigned OW   = FRAC_BITS + 1;
  localparam int unsigned NW   = FRAC_BITS + 18;
  localparam int unsigned CW   = ((NW > DW + QW) ? NW : DW + QW) + 1;
  localparam int unsigned EW   = FRAC_BITS + 18;

  logic adv;
  logic out_vld_q;
  rmq_rsp_t rsp_q, rsp_d;

  // Advance the chain unless a response waits
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Front stage
  logic          f_vld;
  rmq_side_t     f_side;
  logic [VW-1:0] f_v;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .RADW(RADW), .VW(VW)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_valid_i),
    .req_i  (in_req_i),
    .vld_o  (f_vld),
    .side_o (f_side),
    .v_o    (f_v)
  );

  // Square root chain
  logic           s_vld  [RTW+1];
  rmq_side_t      s_side [RTW+1];
  logic [SW-1:0]  s_rem  [RTW+1];
  logic [RTW-1:0] s_q    [RTW+1];

  assign s_vld[0]  = f_vld;
  assign s_side[0] = f_side;
  assign s_rem[0]  = SW'(f_v);
  assign s_q[0]    = '0;

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    rmq_sqrt_cell #(.SW(SW), .RTW(RTW), .BIT(RTW - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (s_vld[k]),
      .side_i (s_side[k]),
      .rem_i  (s_rem[k]),
      .q_i    (s_q[k]),
      .vld_o  (s_vld[k+1]),
      .side_o (s_side[k+1]),
      .rem_o  (s_rem[k+1]),
      .q_o    (s_q[k+1])
    );
  end

  // Divider setup: dividends, divisor, overflow and own component
  localparam logic [CW-1:0] OneC = CW'(1) << FRAC_BITS;

  logic [RTW-1:0]         root;
  logic signed [NumW-1:0] nsel [3];
  logic [NumW-1:0]        nmag [3];
  logic [CW-1:0]          nval [3];
  logic [CW-1:0]          dlim;
  logic [CW-1:0]          ownx;
  rmq_dside_t             p_side_d;

  always_comb begin
    root    = s_q[RTW];
    nsel[0] = s_side[RTW].n0;
    nsel[1] = s_side[RTW].n1;
    nsel[2] = s_side[RTW].n2;
    dlim    = CW'({root, 1'b0}) << QW;
    p_side_d.branch  = s_side[RTW].branch;
    p_side_d.invalid = s_side[RTW].invalid;
    for (int k = 0; k < 3; k++) begin
      nmag[k] = nsel[k][NumW-1] ? NumW'(-nsel[k]) : NumW'(nsel[k]);
      nval[k] = (CW'(nmag[k]) << FRAC_BITS) + CW'(root);
      p_side_d.neg[k] = nsel[k][NumW-1];
      p_side_d.ovf[k] = (nval[k] >= dlim);
    end
    ownx = (CW'(root) + CW'(1)) >> 1;
    if (ownx > OneC) begin
      ownx = OneC;
    end
  end

  logic          p_vld_q;
  rmq_dside_t    p_side_q;
  logic [DW-1:0] p_d_q;
  logic [OW-1:0] p_own_q;
  logic [CW-1:0] p_rem_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= s_vld[RTW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_side_q <= p_side_d;
      p_d_q    <= {root, 1'b0};
      p_own_q  <= ownx[OW-1:0];
      p_rem_q  <= nval;
    end
  end

  // Divider chain
  logic          d_vld  [QW+1];
  rmq_dside_t    d_side [QW+1];
  logic [DW-1:0] d_d    [QW+1];
  logic [OW-1:0] d_own  [QW+1];
  logic [CW-1:0] d_rem  [QW+1][3];
  logic [QW-1:0] d_q    [QW+1][3];

  assign d_vld[0]  = p_vld_q;
  assign d_side[0] = p_side_q;
  assign d_d[0]    = p_d_q;
  assign d_own[0]  = p_own_q;
  assign d_rem[0]  = p_rem_q;
  assign d_q[0]    = '{default: '0};

  for (genvar k = 0; k < QW; k++) begin : g_div
    rmq_div_cell #(
      .CW(CW), .QW(QW), .DW(DW), .OW(OW), .BIT(QW - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (d_vld[k]),
      .side_i (d_side[k]),
      .d_i    (d_d[k]),
      .own_i  (d_own[k]),
      .rem_i  (d_rem[k]),
      .q_i    (d_q[k]),
      .vld_o  (d_vld[k+1]),
      .side_o (d_side[k+1]),
      .d_o    (d_d[k+1]),
      .own_o  (d_own[k+1]),
      .rem_o  (d_rem[k+1]),
      .q_o    (d_q[k+1])
    );
  end

  // Saturate, sign and place the components
  localparam logic [QW-1:0] OneQ = QW'(1) << FRAC_BITS;

  logic [QW-1:0]        lmag [3];
  logic signed [EW-1:0] lval [3];
  logic [DataW-1:0]     lf   [3];
  logic [DataW-1:0]     of;
  rmq_dside_t           ls;

  always_comb begin
    ls = d_side[QW];
    for (int k = 0; k < 3; k++) begin
      lmag[k] = (ls.ovf[k] || d_q[QW][k] > OneQ) ? OneQ : d_q[QW][k];
      lval[k] = ls.neg[k] ? -EW'(lmag[k]) : EW'(lmag[k]);
      lf[k]   = ls.invalid ? '0 : lval[k][DataW-1:0];
    end
    of = ls.invalid ? '0 : DataW'(EW'(d_own[QW]));
    rsp_d.branch  = ls.branch;
    rsp_d.invalid = ls.invalid;
    case (ls.branch)
      BrTrace: begin
        rsp_d.qw = of;    rsp_d.qx = lf[0]; rsp_d.qy = lf[1]; rsp_d.qz = lf[2];
      end
      BrM00: begin
        rsp_d.qw = lf[0]; rsp_d.qx = of;    rsp_d.qy = lf[1]; rsp_d.qz = lf[2];
      end
      BrM11: begin
        rsp_d.qw = lf[0]; rsp_d.qx = lf[1]; rsp_d.qy = of;    rsp_d.qz = lf[2];
      end
      default: begin
        rsp_d.qw = lf[0]; rsp_d.qx = lf[1]; rsp_d.qy = lf[2]; rsp_d.qz = of;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_vld[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  // Checks
  `RMQ_ASSERT(a_invalid_zero, out_vld_q && rsp_q.invalid |-> rsp_q.qw == 0 && rsp_q.qx == 0 && rsp_q.qy == 0 && rsp_q.qz == 0, "invalid response with nonzero components")
  `RMQ_ASSERT(a_own_nonzero, d_vld[QW] && !d_side[QW].invalid |-> d_own[QW] != 0, "own component is zero for a positive radicand")
  `RMQ_ASSERT_NEXT(a_chain_to_out, adv && d_vld[QW], out_vld_q, "result lost between divider and response register")
endmodule
